// ===== design/plldiv_pkg.sv =====
package plldiv_pkg;

   localparam int DIVIDEND_W = 64;
   localparam int DIVISOR_W  = 40;
   localparam int STEP_W     = 6;

   localparam int FREQ_W     = 32;
   localparam int INT_MIN_W  = 19;
   localparam int NOUT_W     = 6;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_HIGH = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OUT_LOW  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_REF_OVF  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_VCO_MAX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PFD_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_MIN = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== design/plldiv_divider.sv =====
module plldiv_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [plldiv_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [plldiv_pkg::DIVISOR_W-1:0]  divisor,
   output logic [plldiv_pkg::DIVIDEND_W-1:0] quotient,
   output logic [plldiv_pkg::DIVISOR_W-1:0]  remainder,
   output plldiv_pkg::div_status_type        status
);
   import plldiv_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = '1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== design/pll_integer_divider_solver_core.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_ref_freq_hz, req_out_freq_hz
// rsp       out        rsp_valid/rsp_stall  rsp_out_divider, rsp_ref_divider,
//                                           rsp_int_divider, rsp_status
// csr       in         csr_wr_en            csr_index, csr_wdata
//
// A request that runs to the end takes four 64-step divisions on the shared
// restoring divider (output divider, two ceilings, feedback divider), each
// opened by a start and closed by a done, and then passes the result state.
// A zero output frequency finishes at once, an output too high or too low after
// the first division, a divider overflow after the third.
// req_stall is high while a request is in work; the result sits in an output
// register so the next request is taken while it waits on rsp_stall.
// Reset is synchronous and restores the default limits.
module pll_integer_divider_solver_core #(
   parameter int REF_DIV_BITS = 14,
   parameter int INT_DIV_BITS = 19
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [plldiv_pkg::FREQ_W-1:0]       req_ref_freq_hz,
   input  logic [plldiv_pkg::FREQ_W-1:0]       req_out_freq_hz,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [plldiv_pkg::NOUT_W-1:0]       rsp_out_divider,
   output logic [REF_DIV_BITS-1:0]             rsp_ref_divider,
   output logic [INT_DIV_BITS-1:0]             rsp_int_divider,
   output logic [plldiv_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                                csr_wr_en,
   input  logic [plldiv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [plldiv_pkg::FREQ_W-1:0]       csr_wdata
);
   import plldiv_pkg::*;

   localparam int GAIN_W = FREQ_W + NOUT_W;
   localparam int NEED_W = INT_MIN_W + FREQ_W;
   localparam int PROD_W = GAIN_W + REF_DIV_BITS;

   localparam logic [REF_DIV_BITS-1:0] REF_DIV_MAX = '1;
   localparam logic [INT_DIV_BITS-1:0] INT_DIV_MAX = '1;
   localparam logic [DIVIDEND_W-1:0]   HALF_LIMIT  = 64'd31;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HALF = 3'd1;
   localparam logic [2:0] ST_RDIV = 3'd2;
   localparam logic [2:0] ST_NEED = 3'd3;
   localparam logic [2:0] ST_NINT = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic                    launch_ff, launch_in;
   logic [FREQ_W-1:0]       vco_ff, pfd_ff;
   logic [INT_MIN_W-1:0]    int_min_ff;
   logic [FREQ_W-1:0]       ref_ff, ref_in;
   logic [FREQ_W-1:0]       fo_ff, fo_in;
   logic [GAIN_W-1:0]       gain_ff, gain_in;
   logic [FREQ_W-1:0]       rdiv_ff, rdiv_in;
   logic [NOUT_W-1:0]       nout_ff, nout_in;
   logic [INT_DIV_BITS-1:0] nint_ff, nint_in;
   logic [STATUS_W-1:0]     st_ff, st_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [NOUT_W-1:0]       rsp_nout_ff;
   logic [REF_DIV_BITS-1:0] rsp_rdiv_ff;
   logic [INT_DIV_BITS-1:0] rsp_nint_ff;
   logic [STATUS_W-1:0]     rsp_st_ff;

   logic                    req_take;
   logic                    out_free;
   logic [FREQ_W-1:0]       pfd_eff;
   logic [NEED_W-1:0]       prod_need;
   logic [PROD_W-1:0]       prod_nint;
   logic [DIVIDEND_W-1:0]   div_dividend;
   logic [DIVISOR_W-1:0]    div_divisor;
   logic [DIVIDEND_W-1:0]   div_quo;
   logic [DIVISOR_W-1:0]    div_rem;
   div_status_type          div_st;
   logic [DIVIDEND_W-1:0]   div_ceil;
   logic [DIVIDEND_W-1:0]   rdiv_pick;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pfd_eff   = (pfd_ff == '0) ? FREQ_W'(1) : pfd_ff;
   assign prod_need = NEED_W'(int_min_ff) * NEED_W'(ref_ff);
   assign prod_nint = PROD_W'(gain_ff) * PROD_W'(rdiv_ff[REF_DIV_BITS-1:0]);
   assign div_ceil  = div_quo + DIVIDEND_W'(div_rem != '0);
   assign rdiv_pick = (div_ceil > DIVIDEND_W'(rdiv_ff)) ? div_ceil : DIVIDEND_W'(rdiv_ff);

   always_comb begin
      unique case (state_ff)
         ST_HALF: begin
            div_dividend = DIVIDEND_W'(vco_ff);
            div_divisor  = DIVISOR_W'({fo_ff, 1'b0});
         end
         ST_RDIV: begin
            div_dividend = DIVIDEND_W'(ref_ff);
            div_divisor  = DIVISOR_W'(pfd_eff);
         end
         ST_NEED: begin
            div_dividend = DIVIDEND_W'(prod_need);
            div_divisor  = DIVISOR_W'(gain_ff);
         end
         default: begin
            div_dividend = DIVIDEND_W'(prod_nint);
            div_divisor  = DIVISOR_W'(ref_ff);
         end
      endcase
   end

   plldiv_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (launch_ff),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_st)
   );

   always_comb begin
      state_in     = state_ff;
      launch_in    = 1'b0;
      ref_in       = ref_ff;
      fo_in        = fo_ff;
      gain_in      = gain_ff;
      rdiv_in      = rdiv_ff;
      nout_in      = nout_ff;
      nint_in      = nint_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               ref_in  = (req_ref_freq_hz == '0) ? FREQ_W'(1) : req_ref_freq_hz;
               fo_in   = req_out_freq_hz;
               nout_in = '0;
               rdiv_in = '0;
               nint_in = '0;
               if (req_out_freq_hz == '0) begin
                  st_in    = STATUS_OUT_LOW;
                  state_in = ST_DONE;
               end else begin
                  launch_in = 1'b1;
                  state_in  = ST_HALF;
               end
            end
         end
         ST_HALF: begin
            if (div_st.done) begin
               if (div_quo == '0) begin
                  st_in    = STATUS_OUT_HIGH;
                  state_in = ST_DONE;
               end else if (div_quo > HALF_LIMIT) begin
                  st_in    = STATUS_OUT_LOW;
                  state_in = ST_DONE;
               end else begin
                  nout_in   = {div_quo[NOUT_W-2:0], 1'b0};
                  gain_in   = GAIN_W'(fo_ff) * GAIN_W'({div_quo[NOUT_W-2:0], 1'b0});
                  launch_in = 1'b1;
                  state_in  = ST_RDIV;
               end
            end
         end
         ST_RDIV: begin
            if (div_st.done) begin
               rdiv_in   = div_ceil[FREQ_W-1:0];
               launch_in = 1'b1;
               state_in  = ST_NEED;
            end
         end
         ST_NEED: begin
            if (div_st.done) begin
               if (rdiv_pick > DIVIDEND_W'(REF_DIV_MAX)) begin
                  nout_in  = '0;
                  rdiv_in  = FREQ_W'(REF_DIV_MAX);
                  st_in    = STATUS_REF_OVF;
                  state_in = ST_DONE;
               end else begin
                  rdiv_in   = rdiv_pick[FREQ_W-1:0];
                  launch_in = 1'b1;
                  state_in  = ST_NINT;
               end
            end
         end
         ST_NINT: begin
            if (div_st.done) begin
               nint_in  = (div_quo > DIVIDEND_W'(INT_DIV_MAX)) ? INT_DIV_MAX
                          : div_quo[INT_DIV_BITS-1:0];
               st_in    = STATUS_OK;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vco_ff       <= 32'd3000000000;
         pfd_ff       <= 32'd70000000;
         int_min_ff   <= 19'd16;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            priority case (csr_index)
               CSR_VCO_MAX: vco_ff     <= csr_wdata;
               CSR_PFD_MAX: pfd_ff     <= csr_wdata;
               CSR_INT_MIN: int_min_ff <= csr_wdata[INT_MIN_W-1:0];
               default: ;
            endcase
         end
      end
      ref_ff  <= ref_in;
      fo_ff   <= fo_in;
      gain_ff <= gain_in;
      rdiv_ff <= rdiv_in;
      nout_ff <= nout_in;
      nint_ff <= nint_in;
      st_ff   <= st_in;
      if (state_ff == ST_DONE && out_free) begin
         rsp_nout_ff <= nout_ff;
         rsp_rdiv_ff <= rdiv_ff[REF_DIV_BITS-1:0];
         rsp_nint_ff <= nint_ff;
         rsp_st_ff   <= st_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_divider = rsp_nout_ff;
   assign rsp_ref_divider = rsp_rdiv_ff;
   assign rsp_int_divider = rsp_nint_ff;
   assign rsp_status      = rsp_st_ff;

endmodule
